// ===== rtl/lbc_pkg.sv =====
// ============================================================================
// lbc_pkg
// shared types, constants and round functions of the lblock cbc cipher
// ============================================================================
package lbc_pkg;

    localparam int KEY_COUNT   = 32;               // round keys produced by the schedule
    localparam int ROUND_COUNT = 32;               // feistel rounds run per block, 1 to 32
    localparam int KEY_IDX_W   = $clog2(KEY_COUNT);
    localparam int BLOCK_W     = 64;
    localparam int HALF_W      = 32;
    localparam int KEY_W       = 80;
    localparam int KEY_HIGH_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [KEY_IDX_W-1:0] KEY_LAST   = KEY_IDX_W'(KEY_COUNT - 1);
    localparam logic [KEY_IDX_W-1:0] ROUND_LAST = KEY_IDX_W'(ROUND_COUNT - 1);

    typedef logic [3:0] t_nib;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_IV       = 2'd2,
        REG_DECRYPT  = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREFETCH,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam t_nib SBOX [10][16] = '{
        '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
          4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
        '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
          4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
        '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
          4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
        '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
          4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
        '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
          4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
        '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
          4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
        '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
          4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
        '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
          4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
        '{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
          4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
        '{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
          4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
    };

    // key add, eight nibble s-boxes, nibble permutation
    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] rk);
        logic [HALF_W-1:0] y;
        t_nib              n [8];
        y = half ^ rk;
        for (int j = 0; j < 8; j++) begin
            n[j] = SBOX[j][y[4*j +: 4]];
        end
        return {n[6], n[4], n[7], n[5], n[2], n[0], n[3], n[1]};
    endfunction

    // one step of the key schedule: rotate left 29, s-box top byte, add step number
    function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0]     k,
                                                  input logic [KEY_IDX_W-1:0] idx);
        logic [KEY_W-1:0] rot;
        rot          = {k[50:0], k[79:51]};
        rot[79:76]   = SBOX[9][rot[79:76]];
        rot[75:72]   = SBOX[8][rot[75:72]];
        rot[50:46]   = rot[50:46] ^ 5'(idx);
        return rot;
    endfunction

    function automatic logic [HALF_W-1:0] rotl8(input logic [HALF_W-1:0] v);
        return {v[23:0], v[31:24]};
    endfunction

    function automatic logic [HALF_W-1:0] rotr8(input logic [HALF_W-1:0] v);
        return {v[7:0], v[31:8]};
    endfunction

endpackage

// ===== rtl/lbc_in_if.sv =====
// ============================================================================
// lbc_in_if
// input block channel: valid, ready and the block payload
// ============================================================================
interface lbc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lbc_pkg::BLOCK_W-1:0]   block_in;
    logic                          first_block;

    modport source (output valid, output block_in, output first_block, input ready);
    modport sink   (input valid, input block_in, input first_block, output ready);
endinterface

// ===== rtl/lbc_out_if.sv =====
// ============================================================================
// lbc_out_if
// output block channel: valid, ready and the block payload
// ============================================================================
interface lbc_out_if;
    logic                          valid;
    logic                          ready;
    logic [lbc_pkg::BLOCK_W-1:0]   block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

// ===== rtl/lblock_cbc_cipher_top.sv =====
// ============================================================================
// lblock_cbc_cipher_top
// lblock 64/80 block cipher in cbc mode with an on-chip round key memory
// ============================================================================
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ---------------------------------------
//  i_in      in   valid / ready        block_in (64), first_block (1)
//  o_out     out  valid / ready        block_out (64)
//  i_cfg_*   in   write enable only    index (2), data (64), no read-back
//
//  one block at a time: a prefetch state to prime the key memory read, the
//  round states (one feistel round each, key read from the memory a round
//  ahead) and a done state that hands the result to the output register;
//  the next block is taken only in the idle state after that.
//  after reset or a key write the first block also passes the expand state,
//  writing the round key memory one key per cycle.
//  reset is synchronous, active low, and clears the chain, the control and
//  configuration registers and the key-ready flag; the key memory and the
//  datapath registers are not cleared.
//  a stalled output holds the finished block in the output register while
//  the next block is taken and worked on; it waits only at the final step.
//
module lblock_cbc_cipher_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lbc_in_if.sink                             i_in,
    lbc_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [lbc_pkg::BLOCK_W-1:0]       r_key_low;
    logic [lbc_pkg::KEY_HIGH_W-1:0]    r_key_high;
    logic [lbc_pkg::BLOCK_W-1:0]       r_iv;
    logic                              r_decrypt;

    // control
    lbc_pkg::t_state                   r_state, n_state;
    logic                              r_keys_ready;
    logic [lbc_pkg::KEY_IDX_W-1:0]     r_cnt;      // key index while expanding, round index
    logic [lbc_pkg::KEY_IDX_W-1:0]     r_addr;     // key memory read address
    logic                              r_out_valid;

    // datapath
    logic [lbc_pkg::KEY_W-1:0]         r_kreg;     // running key schedule state
    logic [lbc_pkg::HALF_W-1:0]        r_rk;       // registered key memory read data
    logic [lbc_pkg::BLOCK_W-1:0]       r_data;     // feistel state {right, left}
    logic [lbc_pkg::BLOCK_W-1:0]       r_xor;      // chain value for decrypt output
    logic [lbc_pkg::BLOCK_W-1:0]       r_chain;
    logic [lbc_pkg::BLOCK_W-1:0]       r_out_data;

    // round key memory, one key per entry
    logic [lbc_pkg::HALF_W-1:0]        r_rk_mem [lbc_pkg::KEY_COUNT];

    logic                              w_in_ready;
    logic                              w_in_acc;
    logic                              w_mem_we;
    logic                              w_load_out;
    logic                              w_step;
    logic [lbc_pkg::BLOCK_W-1:0]       w_chain_eff;
    logic [lbc_pkg::HALF_W-1:0]        w_left, w_right, w_f, w_new_half;
    logic [lbc_pkg::BLOCK_W-1:0]       w_round_data;
    logic [lbc_pkg::BLOCK_W-1:0]       w_result;

    // ------------------------------------------------------------------------
    // configuration writes; a key write forces a new key schedule
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv       <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_we) begin
            case (lbc_pkg::t_cfg_reg'(i_cfg_index))
                lbc_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                lbc_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data[lbc_pkg::KEY_HIGH_W-1:0];
                lbc_pkg::REG_IV:       r_iv       <= i_cfg_data;
                lbc_pkg::REG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_keys_ready ? lbc_pkg::ST_PREFETCH : lbc_pkg::ST_EXPAND;
                end
            end
            lbc_pkg::ST_EXPAND: begin
                if (r_cnt == lbc_pkg::KEY_LAST) begin
                    n_state = lbc_pkg::ST_PREFETCH;
                end
            end
            lbc_pkg::ST_PREFETCH: n_state = lbc_pkg::ST_ROUND;
            lbc_pkg::ST_ROUND: begin
                if (r_cnt == lbc_pkg::ROUND_LAST) begin
                    n_state = lbc_pkg::ST_DONE;
                end
            end
            lbc_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = lbc_pkg::ST_IDLE;
                end
            end
            default: n_state = lbc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: control outputs
    // ------------------------------------------------------------------------
    always_comb begin
        w_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_step     = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            lbc_pkg::ST_IDLE:     w_in_ready = 1'b1;
            lbc_pkg::ST_EXPAND:   w_mem_we   = 1'b1;
            lbc_pkg::ST_PREFETCH: ;
            lbc_pkg::ST_ROUND:    w_step     = 1'b1;
            lbc_pkg::ST_DONE:     w_load_out = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign w_in_acc   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // counters and key-ready flag
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_addr       <= '0;
            r_keys_ready <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_cnt  <= '0;
                r_addr <= r_decrypt ? lbc_pkg::ROUND_LAST : '0;
            end else if (w_mem_we) begin
                r_cnt <= (r_cnt == lbc_pkg::KEY_LAST) ? '0 : r_cnt + 1'b1;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            // read address walks one key per cycle while priming and rounding
            if (r_state == lbc_pkg::ST_PREFETCH || w_step) begin
                r_addr <= r_decrypt ? r_addr - 1'b1 : r_addr + 1'b1;
            end
            if (i_cfg_we && (lbc_pkg::t_cfg_reg'(i_cfg_index) == lbc_pkg::REG_KEY_LOW ||
                             lbc_pkg::t_cfg_reg'(i_cfg_index) == lbc_pkg::REG_KEY_HIGH)) begin
                r_keys_ready <= 1'b0;
            end else if (w_mem_we && r_cnt == lbc_pkg::KEY_LAST) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // key schedule and round key memory (write during expand, read a round ahead)
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kreg <= {r_key_high, r_key_low};
        end else if (w_mem_we) begin
            r_kreg <= lbc_pkg::key_next(r_kreg, r_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_rk_mem[r_cnt] <= r_kreg[79:48];
        end
        r_rk <= r_rk_mem[r_addr];
    end

    // ------------------------------------------------------------------------
    // feistel round datapath
    // ------------------------------------------------------------------------
    assign w_chain_eff = i_in.first_block ? r_iv : r_chain;
    assign w_left      = r_data[31:0];
    assign w_right     = r_data[63:32];
    assign w_f         = lbc_pkg::round_f(r_decrypt ? w_left : w_right, r_rk);
    assign w_new_half  = r_decrypt ? lbc_pkg::rotr8(w_right ^ w_f)
                                   : (lbc_pkg::rotl8(w_left) ^ w_f);
    // encrypt: right becomes new, left takes old right; decrypt: mirror image
    assign w_round_data = r_decrypt ? {w_left, w_new_half} : {w_new_half, w_right};
    assign w_result     = r_decrypt ? (r_data ^ r_xor) : r_data;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data <= r_decrypt ? i_in.block_in : (i_in.block_in ^ w_chain_eff);
            r_xor  <= w_chain_eff;
        end else if (w_step) begin
            r_data <= w_round_data;
        end
    end

    // chain: ciphertext of this block, taken at input for decrypt, at output for encrypt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (w_in_acc) begin
            r_chain <= r_decrypt ? i_in.block_in : w_chain_eff;
        end else if (w_load_out && !r_decrypt) begin
            r_chain <= w_result;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.block_out = r_out_data;

endmodule
